// ===== design/rsa_pkg.sv =====
// shared types and constants for the request statistics accumulator
`default_nettype none

package rsa_pkg;

	// field widths
	localparam int unsigned IN_W    = 32;
	localparam int unsigned TOTAL_W = 47;
	localparam int unsigned W31     = 31;
	localparam int unsigned WSUM_W  = 64;
	localparam int unsigned PROD_W  = 2 * W31;

	// divider step count and counter width
	localparam int unsigned DIV_STEPS = WSUM_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// one daily record transaction
	typedef struct packed {
		logic signed [IN_W-1:0] requests;
		logic signed [IN_W-1:0] failures;
		logic signed [IN_W-1:0] latency_q16;
		logic                   has_day;
		logic                   last_item;
	} rsa_in_t;

	// one result transaction
	typedef struct packed {
		logic [TOTAL_W-1:0] running_total;
		logic               entry_valid;
		logic               final_res;
		logic [W31-1:0]     worst_increase;
		logic [W31-1:0]     mean_latency_q16;
		logic               mean_present;
		logic [1:0]         status;
	} rsa_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic load_out;
		logic clear;
	} rsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic total_nz;
		logic div_done;
	} rsa_sts_t;

endpackage

`default_nettype wire

// ===== design/request_stats_accumulator.sv =====
// top level of the request statistics accumulator
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------
//  day      | in        | day_valid / day_ready  | day_data (rsa_in_t)
//  res      | out       | res_valid / res_ready  | res_data (rsa_out_t)
//
// a day transaction passes through capture with multiply, accumulate and write back
// a closing transaction with a nonzero total also passes through the
// one-bit-per-cycle divider (64 steps plus load and check)
// a finished result waits in the output register while the next transaction is taken
// reset clears all accumulators and status to zero, ok
`default_nettype none

module request_stats_accumulator (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             day_valid,
	output logic                  day_ready,
	input  wire rsa_pkg::rsa_in_t day_data,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output rsa_pkg::rsa_out_t     res_data
);
	import rsa_pkg::*;

	rsa_cmd_t cmd;
	rsa_sts_t sts;

	// sequencing
	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.day_valid (day_valid),
		.day_ready (day_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and state
	rsa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.day_data (day_data),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (res_data)
	);

endmodule

`default_nettype wire

// ===== design/rsa_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module rsa_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [rsa_pkg::WSUM_W-1:0]     dividend,
	input  wire logic [rsa_pkg::TOTAL_W-1:0]    divisor,
	output logic                                busy,
	output logic [rsa_pkg::WSUM_W-1:0]          quotient
);
	import rsa_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TOTAL_W:0]     rem_q;
	logic [WSUM_W-1:0]    quo_q;
	logic [TOTAL_W-1:0]   div_q;

	logic [TOTAL_W:0]     shifted;
	logic [TOTAL_W+1:0]   diff;

	// one trial subtraction per step
	assign shifted = {rem_q[TOTAL_W-1:0], quo_q[WSUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TOTAL_W+1]) begin
				rem_q <= diff[TOTAL_W:0];
				quo_q <= {quo_q[WSUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WSUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == DIV_CNT_W'(DIV_STEPS))
		else $error("divider did not start");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with no steps left");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("divider step count skipped");
`endif

endmodule

`default_nettype wire

// ===== design/rsa_datapath.sv =====
// accumulators, input stage, divider and result register
`default_nettype none

module rsa_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rsa_pkg::rsa_in_t day_data,
	input  wire rsa_pkg::rsa_cmd_t cmd,
	output rsa_pkg::rsa_sts_t     sts,
	output rsa_pkg::rsa_out_t     res_data
);
	import rsa_pkg::*;

	// input stage
	logic [W31-1:0]    req_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              bad_s1;
	logic              has_day_s1;
	logic              last_s1;

	// accumulators
	logic [TOTAL_W-1:0] total_q;
	logic [W31-1:0]     prev_q;
	logic [W31-1:0]     worst_q;
	logic [WSUM_W-1:0]  wsum_q;
	logic               seen_q;
	logic [1:0]         status_q;
	logic               entry_q;

	rsa_out_t res_q;

	logic               bad_in;
	logic               day_ok;
	logic [W31-1:0]     inc;
	logic [TOTAL_W:0]   total_sum;
	logic [WSUM_W:0]    wsum_sum;
	logic               div_busy;
	logic [WSUM_W-1:0]  quotient;
	logic [W31-1:0]     mean_clamped;

	// record checks on the incoming transaction
	assign bad_in = day_data.requests < 0 || day_data.failures < 0 ||
		day_data.latency_q16 < 0 || day_data.failures > day_data.requests;

	// capture and multiply
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1     <= day_data.requests[W31-1:0];
			prod_s1    <= day_data.latency_q16[W31-1:0] * day_data.requests[W31-1:0];
			bad_s1     <= bad_in;
			has_day_s1 <= day_data.has_day;
			last_s1    <= day_data.last_item;
		end
	end

	assign day_ok    = has_day_s1 && !bad_s1;
	assign inc       = req_s1 - prev_q;
	assign total_sum = {1'b0, total_q} + {{(TOTAL_W+1-W31){1'b0}}, req_s1};
	assign wsum_sum  = {1'b0, wsum_q} + {{(WSUM_W+1-PROD_W){1'b0}}, prod_s1};

	// accumulator update and clear at the end of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			prev_q   <= '0;
			worst_q  <= '0;
			wsum_q   <= '0;
			seen_q   <= 1'b0;
			status_q <= ST_OK;
			entry_q  <= 1'b0;
		end else if (cmd.clear) begin
			total_q  <= '0;
			prev_q   <= '0;
			worst_q  <= '0;
			wsum_q   <= '0;
			seen_q   <= 1'b0;
			status_q <= ST_OK;
			entry_q  <= 1'b0;
		end else if (cmd.update) begin
			entry_q <= day_ok;
			if (has_day_s1 && bad_s1) begin
				status_q <= ST_INVALID;
			end
			if (day_ok) begin
				if (seen_q && req_s1 > prev_q && inc > worst_q) begin
					worst_q <= inc;
				end
				prev_q <= req_s1;
				seen_q <= 1'b1;
				total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				if (wsum_sum[WSUM_W]) begin
					wsum_q <= '1;
					if (status_q == ST_OK) begin
						status_q <= ST_OVERFLOW;
					end
				end else begin
					wsum_q <= wsum_sum[WSUM_W-1:0];
				end
			end
		end
	end

	// weighted sum over total
	rsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (wsum_q),
		.divisor  (total_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign mean_clamped = (quotient[WSUM_W-1:W31] != '0) ? '1 : quotient[W31-1:0];

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.running_total    <= total_q;
			res_q.entry_valid      <= entry_q;
			res_q.final_res        <= last_s1;
			res_q.worst_increase   <= last_s1 ? worst_q : '0;
			res_q.mean_latency_q16 <= (last_s1 && total_q != '0) ? mean_clamped : '0;
			res_q.mean_present     <= last_s1 && total_q != '0;
			res_q.status           <= status_q;
		end
	end

	assign res_data     = res_q;
	assign sts.last     = last_s1;
	assign sts.total_nz = total_q != '0;
	assign sts.div_done = !div_busy;

endmodule

`default_nettype wire

// ===== design/rsa_ctrl.sv =====
// controller state machine and result valid flag
`default_nettype none

module rsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              day_valid,
	output logic                   day_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	input  wire rsa_pkg::rsa_sts_t sts,
	output rsa_pkg::rsa_cmd_t      cmd
);
	import rsa_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACC   = 3'd1;
	localparam logic [2:0] S_DLOAD = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_WB    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       load;

	assign day_ready = state_q == S_IDLE;
	assign load      = state_q == S_WB && (!out_valid_q || res_ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (day_valid) state_nxt = S_ACC;
			end
			S_ACC: begin
				state_nxt = sts.last ? S_DLOAD : S_WB;
			end
			S_DLOAD: begin
				state_nxt = sts.total_nz ? S_DIV : S_WB;
			end
			S_DIV: begin
				if (sts.div_done) state_nxt = S_WB;
			end
			S_WB: begin
				if (load) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// commands
	assign cmd.capture   = day_valid && state_q == S_IDLE;
	assign cmd.update    = state_q == S_ACC;
	assign cmd.div_start = state_q == S_DLOAD && sts.total_nz;
	assign cmd.load_out  = load;
	assign cmd.clear     = load && sts.last;
	assign res_valid     = out_valid_q;

`ifndef SYNTHESIS
	a_accept_acc: assert property (@(posedge clk) disable iff (!arst_n)
		day_valid && day_ready |=> state_q == S_ACC)
		else $error("accepted transaction not processed");
	a_div_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && sts.div_done |=> state_q == S_WB)
		else $error("divider finish missed");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && state_q == S_IDLE)
		else $error("result load lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid_q || res_ready)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== verif/request_stats_accumulator_tb.sv =====
// testbench for the request statistics accumulator with a self-checking result predictor
module request_stats_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsa_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 5;
	localparam int RANDOM_ITEMS    = 850;
	localparam int DRAIN_CYCLES    = 200;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int IDLE_PERCENT    = 21;
	localparam int STEADY_FROM     = 150;
	localparam int STEADY_TO       = 400;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [IN_W-1:0]    REQ_MAX    = 32'h7FFF_FFFF;
	localparam logic [IN_W-1:0]    SIGN_BIT   = 32'h8000_0000;
	localparam logic [TOTAL_W-1:0] TOTAL_CEIL = '1;

	// one queued day transaction, optionally held until all results are in
	typedef struct packed {
		rsa_in_t rec;
		logic    drain_first;
	} pending_day_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     day_valid = 1'b0;
	logic     day_ready;
	rsa_in_t  day_data  = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	rsa_out_t res_data;

	pending_day_t pending_days[$];
	rsa_out_t     awaited_results[$];

	int sent_total    = 0;
	int results_done  = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	int sets_closed   = 0;
	int invalid_sets  = 0;
	int overflow_sets = 0;

	// running statistics of the open set
	logic [TOTAL_W-1:0] set_total      = '0;
	logic [IN_W-1:0]    prior_requests = '0;
	logic [W31-1:0]     peak_gain      = '0;
	logic [WSUM_W-1:0]  latency_weight = '0;
	logic               day_seen       = 1'b0;
	logic [1:0]         set_status     = ST_OK;

	request_stats_accumulator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.day_valid (day_valid),
		.day_ready (day_ready),
		.day_data  (day_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// append to the tail of the stimulus queue
	function automatic void enqueue_day(pending_day_t item);
		pending_days = {pending_days, item};
	endfunction

	// append to the tail of the expected result queue
	function automatic void enqueue_result(rsa_out_t res);
		awaited_results = {awaited_results, res};
	endfunction

	// fold one day into the set statistics and return the result it produces
	function automatic rsa_out_t account_day(rsa_in_t rec);
		rsa_out_t          res;
		logic [PROD_W-1:0] prod;
		logic [TOTAL_W:0]  grown_total;
		logic [WSUM_W:0]   grown_weight;
		logic [IN_W-1:0]   gain;
		logic [WSUM_W-1:0] quotient;
		logic              bad;
		res = '0;
		if (rec.has_day) begin
			bad = rec.requests[IN_W-1] || rec.failures[IN_W-1] || rec.latency_q16[IN_W-1]
				|| (rec.failures > rec.requests);
			if (bad) begin
				set_status = ST_INVALID;
			end else begin
				res.entry_valid = 1'b1;
				prod = rec.latency_q16[W31-1:0] * rec.requests[W31-1:0];
				gain = rec.requests - prior_requests;
				if (day_seen && rec.requests > prior_requests && gain[W31-1:0] > peak_gain)
					peak_gain = gain[W31-1:0];
				prior_requests = rec.requests;
				day_seen = 1'b1;
				grown_total = set_total + rec.requests;
				set_total = (grown_total > TOTAL_CEIL) ? TOTAL_CEIL : grown_total[TOTAL_W-1:0];
				grown_weight = latency_weight + prod;
				// weighted sum saturates, invalid status wins over overflow
				if (grown_weight[WSUM_W]) begin
					latency_weight = '1;
					if (set_status == ST_OK)
						set_status = ST_OVERFLOW;
				end else begin
					latency_weight = grown_weight[WSUM_W-1:0];
				end
			end
		end
		res.running_total = set_total;
		res.final_res     = rec.last_item;
		res.status        = set_status;
		// closing transaction reports the summary and starts a fresh set
		if (rec.last_item) begin
			res.worst_increase = peak_gain;
			if (set_total != 0) begin
				quotient = latency_weight / set_total;
				res.mean_latency_q16 = (quotient > REQ_MAX) ? REQ_MAX[W31-1:0]
					: quotient[W31-1:0];
				res.mean_present = 1'b1;
			end
			set_total      = '0;
			prior_requests = '0;
			peak_gain      = '0;
			latency_weight = '0;
			day_seen       = 1'b0;
			set_status     = ST_OK;
		end
		return res;
	endfunction

	// random idle decision outside the steady stretch
	function automatic bit take_break(int progress);
		return !(progress >= STEADY_FROM && progress < STEADY_TO)
			&& $urandom_range(99) < IDLE_PERCENT;
	endfunction

	function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("result %0d %s: expected %0h, got %0h", results_done, what, want, got);
	endfunction

	task automatic queue_record(input logic [IN_W-1:0] req, fail, lat,
			input logic has, last, drain);
		pending_day_t item;
		item.rec.requests    = req;
		item.rec.failures    = fail;
		item.rec.latency_q16 = lat;
		item.rec.has_day     = has;
		item.rec.last_item   = last;
		item.drain_first     = drain;
		enqueue_day(item);
	endtask

	// random day record, mostly well formed, heavy ones push the weighted sum
	function automatic rsa_in_t random_record(bit heavy);
		rsa_in_t         rec;
		logic [IN_W-1:0] req;
		int unsigned     band;
		band = $urandom_range(99);
		if (heavy)
			req = 32'h4000_0000 | ($urandom & 32'h3FFF_FFFF);
		else if (band < 40)
			req = $urandom_range(1000);
		else if (band < 70)
			req = $urandom_range(32'h0010_0000);
		else if (band < 85)
			req = $urandom & REQ_MAX;
		else if (band < 92)
			req = REQ_MAX - $urandom_range(2);
		else
			req = '0;
		rec.requests    = req;
		rec.failures    = $urandom_range(req);
		rec.latency_q16 = (heavy || $urandom_range(1)) ? ($urandom & REQ_MAX)
			: $urandom_range(32'h00FF_FFFF);
		rec.has_day     = 1'b1;
		rec.last_item   = 1'b0;
		// break a share of the records
		band = $urandom_range(99);
		if (band < 3) begin
			rec.requests = $urandom | SIGN_BIT;
		end else if (band < 6) begin
			rec.failures = $urandom | SIGN_BIT;
		end else if (band < 9) begin
			rec.latency_q16 = $urandom | SIGN_BIT;
		end else if (band < 12 && req != REQ_MAX) begin
			rec.failures = req + 1 + $urandom_range(REQ_MAX - req - 1);
		end else if (band < 19) begin
			rec.requests    = $urandom;
			rec.failures    = $urandom;
			rec.latency_q16 = $urandom;
			rec.has_day     = (band < 14);
		end
		return rec;
	endfunction

	// driver: present queued day transactions, hold where a drain is requested
	always @(posedge clk or negedge arst_n) begin : drive_days
		pending_day_t next_day;
		if (!arst_n) begin
			day_valid <= 1'b0;
			day_data  <= '0;
		end else begin
			if (day_valid && day_ready)
				sent_total++;
			if (!day_valid || day_ready) begin
				if (pending_days.size() != 0
						&& !(pending_days[0].drain_first && sent_total != results_done)
						&& !take_break(sent_total)) begin
					next_day = pending_days.pop_front();
					day_valid <= 1'b1;
					day_data  <= next_day.rec;
				end else begin
					day_valid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= !take_break(results_done);
		end
	end

	// monitor: predict on accepted days, check accepted results in order
	always @(posedge clk) begin : watch_results
		rsa_out_t want;
		if (arst_n) begin
			if (day_valid && day_ready)
				enqueue_result(account_day(day_data));
			if (res_valid && res_ready) begin
				results_done <= results_done + 1;
				if (awaited_results.size() == 0) begin
					note_mismatch("with nothing awaited, running_total", '0,
						64'(res_data.running_total));
				end else begin
					want = awaited_results.pop_front();
					if (res_data.running_total !== want.running_total)
						note_mismatch("running_total", 64'(want.running_total),
							64'(res_data.running_total));
					if (res_data.entry_valid !== want.entry_valid)
						note_mismatch("entry_valid", 64'(want.entry_valid),
							64'(res_data.entry_valid));
					if (res_data.final_res !== want.final_res)
						note_mismatch("final_res", 64'(want.final_res), 64'(res_data.final_res));
					if (res_data.worst_increase !== want.worst_increase)
						note_mismatch("worst_increase", 64'(want.worst_increase),
							64'(res_data.worst_increase));
					if (res_data.mean_latency_q16 !== want.mean_latency_q16)
						note_mismatch("mean_latency_q16", 64'(want.mean_latency_q16),
							64'(res_data.mean_latency_q16));
					if (res_data.mean_present !== want.mean_present)
						note_mismatch("mean_present", 64'(want.mean_present),
							64'(res_data.mean_present));
					if (res_data.status !== want.status)
						note_mismatch("status", 64'(want.status), 64'(res_data.status));
					if (want.final_res) begin
						sets_closed++;
						if (want.status == ST_INVALID)
							invalid_sets++;
						if (want.status == ST_OVERFLOW)
							overflow_sets++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin : build_stimulus
		pending_day_t item;
		int unsigned  set_len;
		int unsigned  made;
		bit           heavy;

		// empty set, then a set holding only a zero-request day
		queue_record(0, 0, 0, 1'b0, 1'b1, 1'b0);
		queue_record(0, 0, 0, 1'b1, 1'b1, 1'b0);
		// rises and a drop, failures equal to requests, a no-day item mid set
		queue_record(100, 5, 32'h0001_8000, 1'b1, 1'b0, 1'b0);
		queue_record(300, 0, 32'h0002_0000, 1'b1, 1'b0, 1'b0);
		queue_record(50, 50, 32'h0000_4000, 1'b1, 1'b0, 1'b0);
		queue_record(400, 1, 32'h0010_0000, 1'b1, 1'b0, 1'b0);
		queue_record('1, '1, '1, 1'b0, 1'b0, 1'b0);
		queue_record(10, 0, REQ_MAX, 1'b1, 1'b1, 1'b0);
		// each kind of invalid record, then a good day
		queue_record(SIGN_BIT, 0, 1, 1'b1, 1'b0, 1'b1);
		queue_record(5, '1, 1, 1'b1, 1'b0, 1'b0);
		queue_record(5, 0, SIGN_BIT, 1'b1, 1'b0, 1'b0);
		queue_record(5, 6, 1, 1'b1, 1'b0, 1'b0);
		queue_record(7, 3, 32'h0003_0000, 1'b1, 1'b1, 1'b0);
		// full-scale increase and weighted sum overflow
		queue_record(0, 0, 0, 1'b1, 1'b0, 1'b0);
		for (int i = 0; i < 4; i++)
			queue_record(REQ_MAX, 0, REQ_MAX, 1'b1, 1'b0, 1'b0);
		queue_record(REQ_MAX, REQ_MAX, REQ_MAX, 1'b1, 1'b1, 1'b0);
		// overflow followed by an invalid record
		for (int i = 0; i < 5; i++)
			queue_record(REQ_MAX, 0, REQ_MAX, 1'b1, 1'b0, 1'b0);
		queue_record(SIGN_BIT, SIGN_BIT, SIGN_BIT, 1'b1, 1'b1, 1'b0);

		// random sets, closed by a day or by a close-only item
		made = 0;
		while (made < RANDOM_ITEMS) begin
			heavy = $urandom_range(99) < 10;
			set_len = heavy ? $urandom_range(10, 4) : $urandom_range(12);
			for (int unsigned i = 0; i < set_len; i++) begin
				item.rec = random_record(heavy);
				item.drain_first = (i == 0) && (made == 0 || $urandom_range(99) < 4);
				enqueue_day(item);
			end
			if (set_len != 0 && $urandom_range(1)) begin
				pending_days[$].rec.last_item = 1'b1;
			end else begin
				item.rec.requests    = $urandom;
				item.rec.failures    = $urandom;
				item.rec.latency_q16 = $urandom;
				item.rec.has_day     = 1'b0;
				item.rec.last_item   = 1'b1;
				item.drain_first     = (set_len == 0) && $urandom_range(99) < 4;
				enqueue_day(item);
				set_len++;
			end
			made += set_len;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_days.size() != 0 || day_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0d results never arrived", awaited_results.size());
			error_count += awaited_results.size();
		end

		$display("sent %0d day transactions, checked %0d results over %0d closed sets",
			sent_total, results_done, sets_closed);
		$display("sets closing invalid: %0d, closing on weighted overflow: %0d, errors: %0d",
			invalid_sets, overflow_sets, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rsa_pkg.sv
design/rsa_div.sv
design/rsa_datapath.sv
design/rsa_ctrl.sv
design/request_stats_accumulator.sv
verif/request_stats_accumulator_tb.sv
